// ===== rtl/core/tdcb_pkg.sv =====
// Shared types, constants and helpers for the time-delay backstepping attitude law.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`timescale 1ns / 1ps

package tdcb_pkg;

  localparam int ANGLE_W         = 16;
  localparam int GYRO_W          = 16;
  localparam int RATE_W          = 24;
  localparam int DRIVE_W         = 16;
  localparam int LIMIT_W         = 15;
  localparam int FS_W            = 12;
  localparam int GAIN_W          = 16;
  localparam int INV_W           = 32;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int ACCEL_W         = 32;

  // CORDIC: Q30 datapath, angle in Q3.13 becomes Q30 by a left shift.
  localparam int TRIG_ITERATIONS = 16;
  localparam int TRIG_CW         = $clog2(TRIG_ITERATIONS + 1);
  localparam int TRIG_W          = 34;
  localparam int ZW              = 36;
  localparam int ANG_SHIFT       = 30 - 13;
  localparam logic signed [ZW-1:0] Q30_PI      = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] Q30_HALF_PI = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0] Q30_TWO_PI  = ZW'(64'sd6746518852);
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(64'sd652032874);

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  // Body-to-Euler products and the yaw divide.
  localparam int PROD_W = GYRO_W + TRIG_W;          // gyro times sine/cosine
  localparam int W_W    = 48;                       // yaw numerator, signed
  localparam int DIV_N  = W_W - 1;                  // magnitude bits of the numerator
  localparam int DIV_DW = TRIG_W;                   // divisor magnitude bits
  localparam int DIV_CW = $clog2(DIV_N + 1);
  localparam int RPROD_W = RATE_W + TRIG_W;

  // Per-axis lane.
  localparam int MUL_W   = 33;
  localparam int MPROD_W = 2 * MUL_W;
  localparam int T_W     = 62;
  localparam int MAG_W   = T_W - 1;
  localparam int STEP_W  = 4;
  localparam logic [STEP_W-1:0] LANE_LAST = STEP_W'(11);
  localparam int ACC_W   = DRIVE_W + 2;
  localparam int S_W     = DRIVE_W + 1;

  localparam logic [FS_W-1:0] DEFAULT_RATE = FS_W'(400);

  localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K1_TILT,
    CFG_K1_YAW,
    CFG_K2_TILT,
    CFG_K2_YAW,
    CFG_INV_TILT,
    CFG_INV_YAW,
    CFG_DRIVE_LIMIT,
    CFG_SAMPLE_RATE
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIG,
    S_MUL,
    S_SUM,
    S_DLOAD,
    S_DIV,
    S_RMUL,
    S_RADD,
    S_LAW,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic [GAIN_W-1:0] k1;
    logic [GAIN_W-1:0] k2;
    logic [INV_W-1:0]  inv;
  } lane_gain_t;

  function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'(RATE_MAX);
    lo = 64'(RATE_MIN);
    if (v > hi) begin
      return RATE_MAX;
    end else if (v < lo) begin
      return RATE_MIN;
    end
    return RATE_W'(v);
  endfunction

endpackage

// ===== rtl/core/tdcb_cordic.sv =====
// Iterative rotation-mode CORDIC giving sine and cosine of a Q3.13 angle in Q30.
// Depends on tdcb_pkg for widths, angle constants and the arctangent table.
`timescale 1ns / 1ps

module tdcb_cordic (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [tdcb_pkg::ANGLE_W-1:0]  angle,
  output logic signed [tdcb_pkg::TRIG_W-1:0]   sin_o,
  output logic signed [tdcb_pkg::TRIG_W-1:0]   cos_o,
  output logic                                 done
);

  logic                              busy_r, busy_nxt;
  logic [tdcb_pkg::TRIG_CW-1:0]      it_r, it_nxt;
  logic                              done_r, done_nxt;
  logic signed [tdcb_pkg::TRIG_W-1:0] x_r, y_r, sin_r, cos_r;
  logic signed [tdcb_pkg::ZW-1:0]     z_r;
  logic                              neg_r;

  logic signed [tdcb_pkg::ZW-1:0]     z0, z1, z2;
  logic                              fold;
  logic [4:0]                        k;
  logic signed [tdcb_pkg::ZW-1:0]     atan_k;
  logic signed [tdcb_pkg::TRIG_W-1:0] xs, ys;
  logic                              last;

  // Wrap into [-pi, pi], then fold into [-pi/2, pi/2] with the results negated.
  always_comb begin
    z0 = tdcb_pkg::ZW'(angle) <<< tdcb_pkg::ANG_SHIFT;
    if (z0 > tdcb_pkg::Q30_PI) begin
      z1 = z0 - tdcb_pkg::Q30_TWO_PI;
    end else if (z0 < -tdcb_pkg::Q30_PI) begin
      z1 = z0 + tdcb_pkg::Q30_TWO_PI;
    end else begin
      z1 = z0;
    end
    fold = 1'b0;
    z2   = z1;
    if (z1 > tdcb_pkg::Q30_HALF_PI) begin
      z2   = z1 - tdcb_pkg::Q30_PI;
      fold = 1'b1;
    end else if (z1 < -tdcb_pkg::Q30_HALF_PI) begin
      z2   = z1 + tdcb_pkg::Q30_PI;
      fold = 1'b1;
    end
  end

  assign k      = 5'(it_r);
  assign atan_k = $signed({{(tdcb_pkg::ZW-32){1'b0}}, tdcb_pkg::ATAN_Q30[k]});
  assign xs     = x_r >>> k;
  assign ys     = y_r >>> k;
  assign last   = (it_r == tdcb_pkg::TRIG_CW'(tdcb_pkg::TRIG_ITERATIONS));

  always_comb begin
    busy_nxt = busy_r;
    it_nxt   = it_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      it_nxt   = '0;
    end else if (busy_r) begin
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        it_nxt = it_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      it_r   <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      it_r   <= it_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= tdcb_pkg::CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= z2;
      neg_r <= fold;
    end else if (busy_r) begin
      if (last) begin
        sin_r <= neg_r ? -y_r : y_r;
        cos_r <= neg_r ? -x_r : x_r;
      end else if (!z_r[tdcb_pkg::ZW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_k;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_k;
      end
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;
  assign done  = done_r;

endmodule

// ===== rtl/core/tdcb_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle, for the yaw rate.
// Depends on tdcb_pkg for the operand widths.
`timescale 1ns / 1ps

module tdcb_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tdcb_pkg::DIV_N-1:0]    dividend,
  input  logic [tdcb_pkg::DIV_DW-1:0]   divisor,
  output logic [tdcb_pkg::DIV_N-1:0]    quot,
  output logic                          done
);

  logic                          busy_r, busy_nxt;
  logic [tdcb_pkg::DIV_CW-1:0]   cnt_r, cnt_nxt;
  logic                          done_r, done_nxt;
  logic [tdcb_pkg::DIV_DW:0]     rem_r;
  logic [tdcb_pkg::DIV_N-1:0]    dd_r;
  logic [tdcb_pkg::DIV_DW-1:0]   dv_r;

  logic [tdcb_pkg::DIV_DW:0]     r2;
  logic                          qbit;
  logic                          last;

  assign r2   = {rem_r[tdcb_pkg::DIV_DW-1:0], dd_r[tdcb_pkg::DIV_N-1]};
  assign qbit = (r2 >= {1'b0, dv_r});
  assign last = (cnt_r == tdcb_pkg::DIV_CW'(tdcb_pkg::DIV_N - 1));

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // The dividend register shifts out numerator bits and takes in quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dd_r  <= dividend;
      dv_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= qbit ? (r2 - {1'b0, dv_r}) : r2;
      dd_r  <= {dd_r[tdcb_pkg::DIV_N-2:0], qbit};
    end
  end

  assign quot = dd_r;
  assign done = done_r;

endmodule

// ===== rtl/core/tdcb_lane.sv =====
// One axis of the control law: differences, gain terms, effectiveness scaling and the
// saturated drive accumulator, sequenced over one shared multiplier. Depends on tdcb_pkg.
`timescale 1ns / 1ps

module tdcb_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tdcb_pkg::lane_ctrl_t                 ctrl,
  input  tdcb_pkg::lane_gain_t                 gain,
  input  logic [tdcb_pkg::FS_W-1:0]            fs,
  input  logic [tdcb_pkg::LIMIT_W-1:0]         lim,
  input  logic signed [tdcb_pkg::ANGLE_W-1:0]  tq,
  input  logic signed [tdcb_pkg::ANGLE_W-1:0]  mx,
  input  logic signed [tdcb_pkg::RATE_W-1:0]   x2,
  output logic signed [tdcb_pkg::DRIVE_W-1:0]  drive,
  output logic                                 done
);

  localparam int AW = tdcb_pkg::ANGLE_W;

  // Stored per-axis state.
  logic signed [AW-1:0]                        pt_r, pt_nxt, ppt_r, ppt_nxt;
  logic signed [tdcb_pkg::RATE_W-1:0]          per_r, per_nxt;
  logic signed [tdcb_pkg::ACCEL_W-1:0]         pea_r, pea_nxt;
  logic signed [tdcb_pkg::DRIVE_W-1:0]         da_r, da_nxt;

  logic                                        busy_r, busy_nxt;
  logic [tdcb_pkg::STEP_W-1:0]                 step_r, step_nxt;
  logic                                        done_r, done_nxt;

  // Working registers.
  logic signed [tdcb_pkg::MPROD_W-1:0]         prod_r;
  logic signed [31:0]                          d2f_r;
  logic signed [30:0]                          qd_r;
  logic [31:0]                                 kprod_r;
  logic signed [tdcb_pkg::T_W-1:0]             t_r;
  logic [tdcb_pkg::MAG_W-1:0]                  mag_r;
  logic                                        neg_r;
  logic [60:0]                                 hi_r;
  logic signed [tdcb_pkg::ACCEL_W-1:0]         x2dot_r;

  logic signed [AW:0]                          d1, dm;
  logic signed [AW+2:0]                        d2;
  logic signed [tdcb_pkg::RATE_W:0]            dx;
  logic [tdcb_pkg::GAIN_W:0]                   ksum;
  logic signed [tdcb_pkg::MUL_W-1:0]           ma, mb, fs_m, ksum_m;
  logic signed [tdcb_pkg::T_W-1:0]             prod_t;
  logic signed [tdcb_pkg::ACCEL_W-1:0]         x2dot_c;

  logic [tdcb_pkg::T_W-1:0]                    ssum;
  logic [tdcb_pkg::T_W-1:0]                    sfull;
  logic [tdcb_pkg::S_W-1:0]                    ssat;
  logic signed [tdcb_pkg::ACC_W-1:0]           sval, acc, acc1, acc2, lim_s, dmax, dmin;

  assign d1     = (AW+1)'(tq) - (AW+1)'(pt_r);
  assign dm     = (AW+1)'(tq) - (AW+1)'(mx);
  assign d2     = (AW+3)'(tq) - ((AW+3)'(pt_r) <<< 1) + (AW+3)'(ppt_r);
  assign dx     = (tdcb_pkg::RATE_W+1)'(x2) - (tdcb_pkg::RATE_W+1)'(per_r);
  assign ksum   = {1'b0, gain.k1} + {1'b0, gain.k2};
  assign fs_m   = {{(tdcb_pkg::MUL_W-tdcb_pkg::FS_W){1'b0}}, fs};
  assign ksum_m = {{(tdcb_pkg::MUL_W-tdcb_pkg::GAIN_W-1){1'b0}}, ksum};
  assign prod_t = tdcb_pkg::T_W'(prod_r);

  // Operand selection for the shared multiplier, one product per step.
  always_comb begin
    case (step_r)
      4'd0: begin
        ma = tdcb_pkg::MUL_W'(d2);
        mb = fs_m;
      end
      4'd1: begin
        ma = tdcb_pkg::MUL_W'(d1);
        mb = fs_m;
      end
      4'd2: begin
        ma = {{(tdcb_pkg::MUL_W-tdcb_pkg::GAIN_W){1'b0}}, gain.k1};
        mb = {{(tdcb_pkg::MUL_W-tdcb_pkg::GAIN_W){1'b0}}, gain.k2};
      end
      4'd3: begin
        ma = tdcb_pkg::MUL_W'(d2f_r);
        mb = fs_m;
      end
      4'd4: begin
        ma = ksum_m;
        mb = tdcb_pkg::MUL_W'(qd_r);
      end
      4'd5: begin
        ma = {1'b0, kprod_r};
        mb = tdcb_pkg::MUL_W'(dm);
      end
      4'd6: begin
        ma = ksum_m;
        mb = tdcb_pkg::MUL_W'(x2);
      end
      4'd7: begin
        ma = tdcb_pkg::MUL_W'(dx);
        mb = fs_m;
      end
      4'd9: begin
        ma = {4'b0, mag_r[60:32]};
        mb = {1'b0, gain.inv};
      end
      4'd10: begin
        ma = {1'b0, mag_r[31:0]};
        mb = {1'b0, gain.inv};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    if (prod_r > tdcb_pkg::MPROD_W'(64'sh7FFFFFFF)) begin
      x2dot_c = 32'sh7FFFFFFF;
    end else if (prod_r < -tdcb_pkg::MPROD_W'(64'sh80000000)) begin
      x2dot_c = 32'sh80000000;
    end else begin
      x2dot_c = prod_r[31:0];
    end
  end

  // Final step: the delta drive is floor(|t| * inv / 2^46), then the accumulator clamps.
  always_comb begin
    ssum  = {1'b0, hi_r} + tdcb_pkg::T_W'(prod_r[63:32]);
    sfull = ssum >> 14;
    if (sfull > tdcb_pkg::T_W'(64'd1 << tdcb_pkg::DRIVE_W)) begin
      ssat = tdcb_pkg::S_W'(64'd1 << tdcb_pkg::DRIVE_W);
    end else begin
      ssat = sfull[tdcb_pkg::S_W-1:0];
    end
    sval  = $signed({1'b0, ssat});
    acc   = tdcb_pkg::ACC_W'(da_r) + (neg_r ? -sval : sval);
    lim_s = $signed({{(tdcb_pkg::ACC_W-tdcb_pkg::LIMIT_W){1'b0}}, lim});
    dmax  = tdcb_pkg::ACC_W'({1'b0, {(tdcb_pkg::DRIVE_W-1){1'b1}}});
    dmin  = -dmax - $signed(tdcb_pkg::ACC_W'(1));
    if (acc > lim_s) begin
      acc1 = lim_s;
    end else if (acc < -lim_s) begin
      acc1 = -lim_s;
    end else begin
      acc1 = acc;
    end
    if (acc1 > dmax) begin
      acc2 = dmax;
    end else if (acc1 < dmin) begin
      acc2 = dmin;
    end else begin
      acc2 = acc1;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    pt_nxt   = pt_r;
    ppt_nxt  = ppt_r;
    per_nxt  = per_r;
    pea_nxt  = pea_r;
    da_nxt   = da_r;
    if (ctrl.clear) begin
      busy_nxt = 1'b0;
      step_nxt = '0;
      pt_nxt   = '0;
      ppt_nxt  = '0;
      per_nxt  = '0;
      pea_nxt  = '0;
      da_nxt   = '0;
    end else if (ctrl.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      if (step_r == tdcb_pkg::LANE_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        pt_nxt   = tq;
        ppt_nxt  = pt_r;
        per_nxt  = x2;
        pea_nxt  = x2dot_r;
        da_nxt   = tdcb_pkg::DRIVE_W'(acc2);
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
      pt_r   <= '0;
      ppt_r  <= '0;
      per_r  <= '0;
      pea_r  <= '0;
      da_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
      pt_r   <= pt_nxt;
      ppt_r  <= ppt_nxt;
      per_r  <= per_nxt;
      pea_r  <= pea_nxt;
      da_r   <= da_nxt;
    end
  end

  // Each product is consumed in the step after the one that forms it. No term can reach the
  // saturation bound at these widths, so the law sum accumulates without clamping.
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (busy_r) begin
      case (step_r)
        4'd0:  t_r     <= -(tdcb_pkg::T_W'(pea_r) <<< 17);
        4'd1:  d2f_r   <= prod_r[31:0];
        4'd2:  qd_r    <= prod_r[30:0];
        4'd3:  kprod_r <= prod_r[31:0];
        4'd4:  t_r     <= t_r + (prod_t <<< 16);
        4'd5:  t_r     <= t_r + (prod_t <<< 8);
        4'd6:  t_r     <= t_r + prod_t;
        4'd7:  t_r     <= t_r - (prod_t <<< 9);
        4'd8: begin
          x2dot_r <= x2dot_c;
          neg_r   <= t_r[tdcb_pkg::T_W-1];
          mag_r   <= t_r[tdcb_pkg::T_W-1] ? tdcb_pkg::MAG_W'(-t_r) : tdcb_pkg::MAG_W'(t_r);
        end
        4'd10: hi_r    <= prod_r[60:0];
        default: begin
        end
      endcase
    end
  end

  assign drive = da_r;
  assign done  = done_r;

endmodule

// ===== rtl/core/tdc_backstepping_attitude_law_top.sv =====
// Top level of the time-delay backstepping attitude law: item capture, Euler-rate
// conversion, three axis lanes and the output register. Depends on tdcb_pkg,
// tdcb_cordic, tdcb_div and tdcb_lane.
//
//   port group   direction  flow control     word
//   in_*         input      in_valid/stall   angles, gyro rates, clear
//   out_*        output     out_valid/stall  three saturated drives
//   cfg_*        input      cfg_valid/ready  register index and data
//
// One item runs through capture, the two CORDIC units side by side, the products and their
// sum, the divider load, the bit-serial yaw divide by cos pitch, the roll product and add,
// the lanes' shared multiplier and the output step before the next item is accepted.
// A clear word goes straight to the output step. in_stall is high from acceptance until
// the result is loaded into the output register, which then holds while out_stall is high.
// Reset is synchronous and active low; configuration writes are always ready.
`timescale 1ns / 1ps

module tdc_backstepping_attitude_law_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [tdcb_pkg::ANGLE_W-1:0]     in_target_roll,
  input  logic signed [tdcb_pkg::ANGLE_W-1:0]     in_target_pitch,
  input  logic signed [tdcb_pkg::ANGLE_W-1:0]     in_target_yaw,
  input  logic signed [tdcb_pkg::ANGLE_W-1:0]     in_meas_roll,
  input  logic signed [tdcb_pkg::ANGLE_W-1:0]     in_meas_pitch,
  input  logic signed [tdcb_pkg::ANGLE_W-1:0]     in_meas_yaw,
  input  logic signed [tdcb_pkg::GYRO_W-1:0]      in_gyro_x,
  input  logic signed [tdcb_pkg::GYRO_W-1:0]      in_gyro_y,
  input  logic signed [tdcb_pkg::GYRO_W-1:0]      in_gyro_z,
  input  logic                                    in_clear,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [tdcb_pkg::DRIVE_W-1:0]     out_drive_roll,
  output logic signed [tdcb_pkg::DRIVE_W-1:0]     out_drive_pitch,
  output logic signed [tdcb_pkg::DRIVE_W-1:0]     out_drive_yaw,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [tdcb_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tdcb_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int AW = tdcb_pkg::ANGLE_W;
  localparam int GW = tdcb_pkg::GYRO_W;
  localparam int RW = tdcb_pkg::RATE_W;
  localparam int DW = tdcb_pkg::DRIVE_W;

  tdcb_pkg::ctrl_state_t state_r, state_nxt;

  // Configuration registers.
  logic [tdcb_pkg::GAIN_W-1:0]  k1_tilt_r, k1_yaw_r, k2_tilt_r, k2_yaw_r;
  logic [tdcb_pkg::INV_W-1:0]   inv_tilt_r, inv_yaw_r;
  logic [tdcb_pkg::LIMIT_W-1:0] limit_r;
  logic [tdcb_pkg::FS_W-1:0]    rate_r;
  logic [tdcb_pkg::FS_W-1:0]    fs;

  // Captured item.
  logic signed [AW-1:0] tq_roll_r, tq_pitch_r, tq_yaw_r;
  logic signed [AW-1:0] mx_roll_r, mx_pitch_r, mx_yaw_r;
  logic signed [GW-1:0] p_r, q_r, r_r;

  // Euler-rate path.
  logic signed [tdcb_pkg::TRIG_W-1:0]  roll_sin, roll_cos, pitch_sin, pitch_cos;
  logic                                roll_done, pitch_done;
  logic signed [tdcb_pkg::PROD_W-1:0]  m_qsr_r, m_rcr_r, m_qcr_r, m_rsr_r;
  logic signed [tdcb_pkg::W_W-1:0]     w_r;
  logic                                cpz_r;
  logic signed [RW-1:0]                roll_r, pitch_r, yaw_r, yaw_c;
  logic signed [tdcb_pkg::RPROD_W-1:0] rprod_r;
  logic [tdcb_pkg::DIV_N-1:0]          div_num, div_q;
  logic [tdcb_pkg::DIV_DW-1:0]         div_den;
  logic                                div_done;
  logic signed [63:0]                  qv;

  // Lanes and output.
  tdcb_pkg::lane_ctrl_t                lane_ctrl;
  tdcb_pkg::lane_gain_t                gain_tilt, gain_yaw;
  logic signed [DW-1:0]                lane_drive [3];
  logic [2:0]                          lane_done;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [DW-1:0]                out_roll_r, out_pitch_r, out_yaw_r;

  logic accept, trig_start, div_start, out_load;

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdcb_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_clear ? tdcb_pkg::S_OUT : tdcb_pkg::S_TRIG;
        end
      end
      tdcb_pkg::S_TRIG:  if (roll_done && pitch_done) state_nxt = tdcb_pkg::S_MUL;
      tdcb_pkg::S_MUL:   state_nxt = tdcb_pkg::S_SUM;
      tdcb_pkg::S_SUM:   state_nxt = tdcb_pkg::S_DLOAD;
      tdcb_pkg::S_DLOAD: state_nxt = tdcb_pkg::S_DIV;
      tdcb_pkg::S_DIV:   if (div_done) state_nxt = tdcb_pkg::S_RMUL;
      tdcb_pkg::S_RMUL:  state_nxt = tdcb_pkg::S_RADD;
      tdcb_pkg::S_RADD:  state_nxt = tdcb_pkg::S_LAW;
      tdcb_pkg::S_LAW:   if (&lane_done) state_nxt = tdcb_pkg::S_OUT;
      tdcb_pkg::S_OUT:   if (!out_valid_r || !out_stall) state_nxt = tdcb_pkg::S_IDLE;
      default:           state_nxt = tdcb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = (state_r != tdcb_pkg::S_IDLE);
    accept          = in_valid && (state_r == tdcb_pkg::S_IDLE);
    trig_start      = accept && !in_clear;
    lane_ctrl.clear = accept && in_clear;
    lane_ctrl.start = (state_r == tdcb_pkg::S_RADD);
    div_start       = (state_r == tdcb_pkg::S_DLOAD);
    out_load        = (state_r == tdcb_pkg::S_OUT) && (!out_valid_r || !out_stall);
    out_valid_nxt   = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdcb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_tilt_r  <= 16'd256;
      k1_yaw_r   <= 16'd256;
      k2_tilt_r  <= 16'd12800;
      k2_yaw_r   <= 16'd12800;
      inv_tilt_r <= 32'd536871;
      inv_yaw_r  <= 32'd429497;
      limit_r    <= 15'd32767;
      rate_r     <= 12'd400;
    end else if (cfg_valid && cfg_ready) begin
      case (tdcb_pkg::cfg_idx_t'(cfg_index))
        tdcb_pkg::CFG_K1_TILT:     k1_tilt_r  <= cfg_data[tdcb_pkg::GAIN_W-1:0];
        tdcb_pkg::CFG_K1_YAW:      k1_yaw_r   <= cfg_data[tdcb_pkg::GAIN_W-1:0];
        tdcb_pkg::CFG_K2_TILT:     k2_tilt_r  <= cfg_data[tdcb_pkg::GAIN_W-1:0];
        tdcb_pkg::CFG_K2_YAW:      k2_yaw_r   <= cfg_data[tdcb_pkg::GAIN_W-1:0];
        tdcb_pkg::CFG_INV_TILT:    inv_tilt_r <= cfg_data[tdcb_pkg::INV_W-1:0];
        tdcb_pkg::CFG_INV_YAW:     inv_yaw_r  <= cfg_data[tdcb_pkg::INV_W-1:0];
        tdcb_pkg::CFG_DRIVE_LIMIT: limit_r    <= cfg_data[tdcb_pkg::LIMIT_W-1:0];
        tdcb_pkg::CFG_SAMPLE_RATE: rate_r     <= cfg_data[tdcb_pkg::FS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A zero rate register means the default control rate.
  assign fs = (rate_r == '0) ? tdcb_pkg::DEFAULT_RATE : rate_r;

  // ---------------- Euler-rate conversion ----------------
  tdcb_cordic u_trig_roll (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (in_meas_roll),
    .sin_o (roll_sin),
    .cos_o (roll_cos),
    .done  (roll_done)
  );

  tdcb_cordic u_trig_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (in_meas_pitch),
    .sin_o (pitch_sin),
    .cos_o (pitch_cos),
    .done  (pitch_done)
  );

  assign div_num = w_r[tdcb_pkg::W_W-1] ? tdcb_pkg::DIV_N'(-w_r) : tdcb_pkg::DIV_N'(w_r);
  assign div_den = pitch_cos[tdcb_pkg::TRIG_W-1] ? tdcb_pkg::DIV_DW'(-pitch_cos)
                                                 : tdcb_pkg::DIV_DW'(pitch_cos);

  tdcb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quot     (div_q),
    .done     (div_done)
  );

  // Yaw rate truncates toward zero; a zero cosine saturates by the numerator's sign.
  always_comb begin
    qv = 64'(div_q);
    if (w_r[tdcb_pkg::W_W-1] ^ pitch_cos[tdcb_pkg::TRIG_W-1]) begin
      qv = -qv;
    end
    if (cpz_r) begin
      if (w_r == '0) begin
        yaw_c = '0;
      end else if (w_r[tdcb_pkg::W_W-1]) begin
        yaw_c = tdcb_pkg::RATE_MIN;
      end else begin
        yaw_c = tdcb_pkg::RATE_MAX;
      end
    end else begin
      yaw_c = tdcb_pkg::sat_rate(qv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tq_roll_r  <= in_target_roll;
      tq_pitch_r <= in_target_pitch;
      tq_yaw_r   <= in_target_yaw;
      mx_roll_r  <= in_meas_roll;
      mx_pitch_r <= in_meas_pitch;
      mx_yaw_r   <= in_meas_yaw;
      p_r        <= in_gyro_x;
      q_r        <= in_gyro_y;
      r_r        <= in_gyro_z;
    end
    if (state_r == tdcb_pkg::S_MUL) begin
      m_qsr_r <= q_r * roll_sin;
      m_rcr_r <= r_r * roll_cos;
      m_qcr_r <= q_r * roll_cos;
      m_rsr_r <= r_r * roll_sin;
    end
    if (state_r == tdcb_pkg::S_SUM) begin
      w_r     <= tdcb_pkg::W_W'(m_qsr_r + m_rcr_r);
      pitch_r <= tdcb_pkg::sat_rate(64'((m_qcr_r - m_rsr_r) >>> 30));
      cpz_r   <= (pitch_cos == '0);
    end
    if ((state_r == tdcb_pkg::S_DIV) && div_done) begin
      yaw_r <= yaw_c;
    end
    if (state_r == tdcb_pkg::S_RMUL) begin
      rprod_r <= yaw_r * pitch_sin;
    end
    if (state_r == tdcb_pkg::S_RADD) begin
      roll_r <= tdcb_pkg::sat_rate(64'(p_r) + 64'(rprod_r >>> 30));
    end
  end

  // ---------------- axis lanes ----------------
  assign gain_tilt = '{k1: k1_tilt_r, k2: k2_tilt_r, inv: inv_tilt_r};
  assign gain_yaw  = '{k1: k1_yaw_r, k2: k2_yaw_r, inv: inv_yaw_r};

  tdcb_lane u_lane_roll (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (lane_ctrl),
    .gain  (gain_tilt),
    .fs    (fs),
    .lim   (limit_r),
    .tq    (tq_roll_r),
    .mx    (mx_roll_r),
    .x2    (roll_r),
    .drive (lane_drive[0]),
    .done  (lane_done[0])
  );

  tdcb_lane u_lane_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (lane_ctrl),
    .gain  (gain_tilt),
    .fs    (fs),
    .lim   (limit_r),
    .tq    (tq_pitch_r),
    .mx    (mx_pitch_r),
    .x2    (pitch_r),
    .drive (lane_drive[1]),
    .done  (lane_done[1])
  );

  tdcb_lane u_lane_yaw (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (lane_ctrl),
    .gain  (gain_yaw),
    .fs    (fs),
    .lim   (limit_r),
    .tq    (tq_yaw_r),
    .mx    (mx_yaw_r),
    .x2    (yaw_r),
    .drive (lane_drive[2]),
    .done  (lane_done[2])
  );

  // The merge stage gathers the three lane drives into one output word.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_roll_r  <= lane_drive[0];
      out_pitch_r <= lane_drive[1];
      out_yaw_r   <= lane_drive[2];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_roll  = out_roll_r;
  assign out_drive_pitch = out_pitch_r;
  assign out_drive_yaw   = out_yaw_r;

endmodule

// ===== rtl/core/tdcb_checker.sv =====
// Port-level checks for the attitude law top level, attached by the bind below.
// Depends on tdc_backstepping_attitude_law_top and tdcb_pkg.
`timescale 1ns / 1ps

module tdcb_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [tdcb_pkg::DRIVE_W-1:0]  out_drive_roll,
  input logic signed [tdcb_pkg::DRIVE_W-1:0]  out_drive_pitch,
  input logic signed [tdcb_pkg::DRIVE_W-1:0]  out_drive_yaw
);

  // One word at a time: the input must close once a word is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted a second word back to back");

  // A new result only appears after the block was working on a word.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a word in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_drive_roll) && $stable(out_drive_pitch)
                                  && $stable(out_drive_yaw)))
    else $error("result changed while stalled");

endmodule

bind tdc_backstepping_attitude_law_top tdcb_checker u_tdcb_checker (.*);
